/* hdl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/stp_pkg.sv */
// types, constants and character helpers for the string to int64 parser
`timescale 1ns / 1ps

package stp_pkg;

  localparam int COUNT_LIMIT_DEF = 4095;
  localparam int CONSUMED_W      = 12;
  localparam int CONSUMED_MAX    = 4095;
  localparam int PHASE_W         = 3;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 7;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd5;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [CONSUMED_W-1:0] consumed;
    logic                  bad_radix;
    logic                  overflow_flag;
    logic signed [63:0]    value;
  } result_t;

  // digit value of a character, DIGIT_NONE when it is no digit at all
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c inside {[8'h30:8'h39]}) begin
      d = DIGIT_W'(c - 8'h30);
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = DIGIT_W'(c - 8'h61 + 8'd10);
    end else if (c inside {[8'h41:8'h5A]}) begin
      d = DIGIT_W'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

  // space, tab, lf, vt, ff, cr
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c inside {[8'd9:8'd13]});
  endfunction

endpackage

/* hdl/stp_core.sv */
// parse state and per-character next-state logic with one multiply-add
`timescale 1ns / 1ps

module stp_core import stp_pkg::*; #(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         character,
  input  logic               start_of_string,
  input  logic [RADIX_W-1:0] radix,
  output logic               emit,
  output result_t            result
);

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);
  localparam int CMP_W = (CNT_W > CONSUMED_W) ? CNT_W : CONSUMED_W;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [63:0]        accumulator, accumulator_next;
  logic               negative, negative_next;
  logic               overflowed, overflowed_next;
  logic [RADIX_W-1:0] active_radix, active_radix_next;
  logic [CNT_W-1:0]   char_count, char_count_next;

  logic               stop;
  logic               do_acc;
  logic               fin;
  logic               bad;
  logic [CNT_W-1:0]   used;
  logic [CMP_W-1:0]   used_x;
  logic [DIGIT_W-1:0] d;
  logic [69:0]        prod;
  logic [69:0]        limit;

  assign d = digit_of(character);

  always_comb begin
    phase_next        = phase;
    accumulator_next  = accumulator;
    negative_next     = negative;
    overflowed_next   = overflowed;
    active_radix_next = active_radix;
    char_count_next   = char_count;
    stop   = 1'b0;
    do_acc = 1'b0;
    fin    = 1'b0;
    bad    = 1'b0;
    used   = '0;

    if (start_of_string) begin
      accumulator_next  = '0;
      negative_next     = 1'b0;
      overflowed_next   = 1'b0;
      char_count_next   = '0;
      active_radix_next = '0;
      phase_next        = PH_IDLE;
      if (radix != RADIX_AUTO && (radix < RADIX_MIN || radix > RADIX_MAX)) begin
        bad  = 1'b1;
        stop = 1'b1;
      end else begin
        active_radix_next = radix;
        phase_next        = PH_LEAD;
      end
    end

    if (!stop && (phase_next < PH_LEAD || phase_next > PH_DIGITS)) begin
      stop = 1'b1;
    end

    if (!stop && phase_next == PH_LEAD) begin
      if (is_space(character)) begin
        stop = 1'b1;
        if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
      end else if (character == 8'h2B || character == 8'h2D) begin
        stop          = 1'b1;
        negative_next = (character == 8'h2D);
        phase_next    = PH_SIGNED;
        if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
      end else begin
        phase_next = PH_SIGNED;
      end
    end

    if (!stop && phase_next == PH_SIGNED) begin
      stop = 1'b1;
      if (character == 8'h30 &&
          (active_radix_next == RADIX_AUTO || active_radix_next == RADIX_HEX)) begin
        phase_next = PH_ZERO;
        if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
      end else begin
        if (active_radix_next == RADIX_AUTO) active_radix_next = RADIX_DEC;
        if (d < {1'b0, active_radix_next}) begin
          do_acc     = 1'b1;
          phase_next = PH_DIGITS;
          if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
        end else begin
          fin  = 1'b1;
          used = '0;
        end
      end
    end

    if (!stop && phase_next == PH_ZERO) begin
      if (character == 8'h78 || character == 8'h58) begin
        stop              = 1'b1;
        active_radix_next = RADIX_HEX;
        phase_next        = PH_PREFIX;
        if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
      end else begin
        if (active_radix_next == RADIX_AUTO) active_radix_next = RADIX_OCT;
        phase_next = PH_DIGITS;
      end
    end

    if (!stop && phase_next == PH_PREFIX) begin
      stop = 1'b1;
      if (d < {1'b0, RADIX_HEX}) begin
        do_acc     = 1'b1;
        phase_next = PH_DIGITS;
        if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
      end else begin
        // bare "0x": the number is the lone zero
        fin  = 1'b1;
        used = (char_count_next != '0) ? char_count_next - 1'b1 : '0;
      end
    end

    if (!stop) begin
      if (d < {1'b0, active_radix_next}) begin
        do_acc = 1'b1;
        if (char_count_next < CNT_W'(COUNT_LIMIT)) char_count_next = char_count_next + 1'b1;
      end else begin
        fin  = 1'b1;
        used = char_count_next;
      end
    end

    if (fin) phase_next = PH_IDLE;

    // acc*base+d > limit is the exact overflow test, acc never exceeds limit
    limit = negative_next ? {6'd0, INT64_MIN} : {6'd0, INT64_MAX};
    prod  = {6'd0, accumulator_next} * {64'd0, active_radix_next} + 70'(d);
    if (do_acc && !overflowed_next) begin
      if (prod > limit) overflowed_next = 1'b1;
      else accumulator_next = prod[63:0];
    end
  end

  assign used_x = CMP_W'(used);
  assign emit   = take && (bad || fin);

  always_comb begin
    result = '0;
    if (bad) begin
      result.bad_radix = 1'b1;
    end else begin
      result.overflow_flag = overflowed_next;
      if (overflowed_next) result.value = negative_next ? INT64_MIN : INT64_MAX;
      else result.value = negative_next ? (64'd0 - accumulator_next) : accumulator_next;
      result.consumed = (used_x > CMP_W'(CONSUMED_MAX)) ? CONSUMED_W'(CONSUMED_MAX)
                                                        : used_x[CONSUMED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      accumulator  <= '0;
      negative     <= 1'b0;
      overflowed   <= 1'b0;
      active_radix <= '0;
      char_count   <= '0;
    end else if (take) begin
      phase        <= phase_next;
      accumulator  <= accumulator_next;
      negative     <= negative_next;
      overflowed   <= overflowed_next;
      active_radix <= active_radix_next;
      char_count   <= char_count_next;
    end
  end

endmodule

/* hdl/string_to_int64_parser.sv */
// streaming string to int64 parser with strtoll rules, top level
`timescale 1ns / 1ps
// usage
//   s channel carries one character per transaction; s_tuser high marks the
//   first character of a string and samples the radix (0 auto, 2..36)
//   a string ends at the first character that is not a digit of the radix,
//   nul included; that transaction yields one m transaction with the value,
//   overflow and bad radix flags and the count of characters consumed
//   a bad radix yields its result in the start transaction itself
//   characters outside a string and a restart mid-string give no result
// throughput and datapath
//   one character per cycle while s_tready is high; a character is parsed in the
//   cycle it is accepted and its result registered into the output or skid stage;
//   the per-cycle path is one 64x6 multiply-add with an exact limit compare
// reset
//   rst clears the parse state to idle and empties output and skid stages
// stalls
//   a two-entry output stage (register plus skid) lets input continue while
//   one result waits; s_tready drops only when the skid entry is full
`include "assert_macros.svh"

module string_to_int64_parser import stp_pkg::*; #(
  parameter int COUNT_LIMIT = COUNT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // character[7:0], radix[13:8], zero[15:14]
  input  logic        s_tuser,   // start_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // value[63:0], overflow_flag[64], bad_radix[65],
                                 // consumed[77:66], zero[79:78]
);

  logic    take;
  logic    emit;
  result_t res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    out_load;
  logic    out_free;

  assign s_tready = !skid_valid;
  assign take     = s_tvalid && s_tready;

  stp_core #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .character       (s_tdata[7:0]),
    .start_of_string (s_tuser),
    .radix           (s_tdata[13:8]),
    .emit            (emit),
    .result          (res)
  );

  // output register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (skid_valid || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid   <= skid_valid || emit;
        skid_valid <= 1'b0;
      end else if (emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && emit) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.consumed, out_res.bad_radix,
                    out_res.overflow_flag, out_res.value};

  `ASSERT_NOW(a_skid_behind_out, skid_valid, m_tvalid, "skid full while output empty")
  `ASSERT_NOW(a_bad_radix_zero, m_tvalid && m_tdata[65],
              m_tdata[63:0] == 64'd0 && !m_tdata[64] && m_tdata[77:66] == 12'd0,
              "bad radix result carries data")
  `ASSERT_NOW(a_overflow_saturates, m_tvalid && m_tdata[64],
              m_tdata[63:0] == INT64_MAX || m_tdata[63:0] == INT64_MIN,
              "overflow result not saturated")

endmodule

/* dv/string_to_int64_parser_tb.sv */
// self-checking testbench for the streaming string to int64 parser
`timescale 1ns / 1ps

module string_to_int64_parser_tb;
  import stp_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 400;       // long receiver hold-off
  localparam int SETTLE_CYCLES = 10;       // result register plus skid, with margin
  localparam int CYCLE_LIMIT  = 1000000;

  // who idles: receiver mostly, sender mostly, nobody
  typedef enum logic [1:0] {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       st;
    logic [5:0] radix;
    pace_t      pace;
    logic       drain;   // hold this character back until no result is outstanding
    logic       hold;    // kick off the long receiver hold-off
  } plan_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // character[7:0], radix[13:8], zero[15:14]
  logic        s_tuser = 1'b0; // start_of_string
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // value[63:0], overflow_flag[64], bad_radix[65],
                               // consumed[77:66], zero[79:78]

  plan_item_t char_plan[$];
  result_t    results_due[$];
  plan_item_t cur;
  pace_t      rx_pace = PACE_FULL;
  logic       hold_toggle = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;
  int         errors = 0;
  int         cycle_count = 0;

  // generator state
  pace_t gen_pace = PACE_RX_SLOW;
  logic  gen_drain = 1'b0;
  logic  gen_hold = 1'b0;
  logic  opening = 1'b0;

  // parser mirror
  logic [2:0]  ps_phase = PH_IDLE;
  logic [63:0] ps_acc = '0;
  logic        ps_neg = 1'b0;
  logic        ps_ovf = 1'b0;
  logic [5:0]  ps_radix = '0;
  int          ps_count = 0;

  string_to_int64_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int tx_idle_pct(pace_t p);
    case (p)
      PACE_RX_SLOW: return 12;
      PACE_TX_SLOW: return 84;
      default:      return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(pace_t p);
    case (p)
      PACE_RX_SLOW: return 84;
      PACE_TX_SLOW: return 12;
      default:      return 0;
    endcase
  endfunction

  // digit value in base 36, 99 when the character is no digit
  function automatic int char_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "Z") return int'(c) - int'("A") + 10;
    return 99;
  endfunction

  function automatic void count_up();
    if (ps_count < COUNT_LIMIT_DEF) ps_count++;
  endfunction

  // acc*base+digit with an exact limit check against the signed range
  function automatic void add_digit(int d);
    logic [63:0] lim;
    logic [63:0] base;
    if (ps_ovf) return;
    lim  = ps_neg ? INT64_MIN : INT64_MAX;
    base = (ps_radix != RADIX_AUTO) ? 64'(ps_radix) : 64'(RADIX_DEC);
    if (ps_acc > (lim - 64'(d)) / base) ps_ovf = 1'b1;
    else ps_acc = ps_acc * base + 64'(d);
  endfunction

  function automatic void close_number(int used);
    result_t r;
    r = '0;
    if (ps_ovf) r.value = ps_neg ? INT64_MIN : INT64_MAX;
    else r.value = ps_neg ? -ps_acc : ps_acc;
    r.overflow_flag = ps_ovf;
    r.consumed = (used > CONSUMED_MAX) ? CONSUMED_W'(CONSUMED_MAX) : CONSUMED_W'(used);
    results_due.push_back(r);
    ps_phase = PH_IDLE;
  endfunction

  // one accepted character through the mirror; queues the result it ends with
  function automatic void parse_char(logic [7:0] c, logic st, logic [5:0] r);
    int      d;
    result_t bad;
    if (st) begin
      ps_phase = PH_IDLE;
      ps_acc   = '0;
      ps_neg   = 1'b0;
      ps_ovf   = 1'b0;
      ps_radix = RADIX_AUTO;
      ps_count = 0;
      if (r != RADIX_AUTO && (r < RADIX_MIN || r > RADIX_MAX)) begin
        bad = '0;
        bad.bad_radix = 1'b1;
        results_due.push_back(bad);
        return;
      end
      ps_radix = r;
      ps_phase = PH_LEAD;
    end
    if (ps_phase < PH_LEAD || ps_phase > PH_DIGITS) return;

    if (ps_phase == PH_LEAD) begin
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
        count_up();
        return;
      end
      if (c == "+" || c == "-") begin
        ps_neg = (c == "-");
        count_up();
        ps_phase = PH_SIGNED;
        return;
      end
      ps_phase = PH_SIGNED;
    end

    if (ps_phase == PH_SIGNED) begin
      if (c == "0" && (ps_radix == RADIX_AUTO || ps_radix == RADIX_HEX)) begin
        count_up();
        ps_phase = PH_ZERO;
        return;
      end
      if (ps_radix == RADIX_AUTO) ps_radix = RADIX_DEC;
      d = char_digit(c);
      if (d < ps_radix) begin
        add_digit(d);
        count_up();
        ps_phase = PH_DIGITS;
        return;
      end
      close_number(0);
      return;
    end

    if (ps_phase == PH_ZERO) begin
      if (c == "x" || c == "X") begin
        ps_radix = RADIX_HEX;
        count_up();
        ps_phase = PH_PREFIX;
        return;
      end
      if (ps_radix == RADIX_AUTO) ps_radix = RADIX_OCT;
      ps_phase = PH_DIGITS;
    end

    if (ps_phase == PH_PREFIX) begin
      d = char_digit(c);
      if (d < RADIX_HEX) begin
        add_digit(d);
        count_up();
        ps_phase = PH_DIGITS;
        return;
      end
      // bare prefix: the number is the lone zero, the x is given back
      close_number(ps_count != 0 ? ps_count - 1 : 0);
      return;
    end

    d = char_digit(c);
    if (d < ps_radix) begin
      add_digit(d);
      count_up();
      return;
    end
    close_number(ps_count);
  endfunction

  // append one character; the first one after opening carries the start flag
  function automatic void add_char(logic [7:0] c, logic [5:0] r);
    plan_item_t it;
    it.ch    = c;
    it.st    = opening;
    it.radix = opening ? r : 6'($urandom_range(63));
    it.pace  = gen_pace;
    it.drain = gen_drain;
    it.hold  = gen_hold;
    opening   = 1'b0;
    gen_drain = 1'b0;
    gen_hold  = 1'b0;
    char_plan.push_back(it);
  endfunction

  function automatic void add_text(string body, logic [5:0] r, logic [7:0] stop);
    opening = 1'b1;
    for (int i = 0; i < body.len(); i++) add_char(body[i], r);
    add_char(stop, r);
  endfunction

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return 8'(int'("0") + d);
    return 8'(($urandom_range(1) ? int'("a") : int'("A")) + d - 10);
  endfunction

  // driver: offers planned characters, predicts on each accepted transaction
  always @(posedge clk) begin
    logic       offer;
    plan_item_t nxt;
    offer = 1'b0;
    nxt   = '0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_char(cur.ch, cur.st, cur.radix);
      end
      if (!s_tvalid || s_tready) begin
        if (char_plan.size() != 0) begin
          nxt = char_plan[0];
          if (nxt.drain && results_due.size() != 0) begin
            offer = 1'b0;
          end else if ($urandom_range(99) < tx_idle_pct(nxt.pace)) begin
            offer = 1'b0;
          end else begin
            offer = 1'b1;
            void'(char_plan.pop_front());
          end
        end
        if (offer) begin
          cur     <= nxt;
          s_tdata <= {2'b00, nxt.radix, nxt.ch};
          s_tuser <= nxt.st;
          rx_pace <= nxt.pace;
          if (nxt.hold) hold_toggle <= ~hold_toggle;
        end
        s_tvalid <= offer;
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[77:0]);
        if (results_due.size() == 0) begin
          $error("unexpected result: value %0d consumed %0d", got.value, got.consumed);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            errors++;
          end
          if (got.overflow_flag !== want.overflow_flag) begin
            $error("overflow_flag: expected %0b, got %0b", want.overflow_flag,
                   got.overflow_flag);
            errors++;
          end
          if (got.bad_radix !== want.bad_radix) begin
            $error("bad_radix: expected %0b, got %0b", want.bad_radix, got.bad_radix);
            errors++;
          end
          if (got.consumed !== want.consumed) begin
            $error("consumed: expected %0d, got %0d", want.consumed, got.consumed);
            errors++;
          end
        end
      end
      // long hold-off so the output stage fills and input backs up
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct(rx_pace));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int         sel;
    int         n;
    int         k;
    int         base;
    int         goal;
    logic [5:0] rdx;
    logic [7:0] c;
    pace_t      last_pace;
    logic       hold_done;

    // directed strings
    opening = 1'b0;
    add_char(8'hFF, 6'd63);                 // stray character while idle, ignored
    add_text("", 6'd63, "7");               // bad radix, top of the field
    add_text("", 6'd1, "1");                // bad radix just below the range
    add_text(" \t-0x1F", RADIX_AUTO, 8'h00); // whitespace, sign, auto hex
    add_text("0x", RADIX_HEX, "g");         // bare prefix
    add_text("017", RADIX_AUTO, "9");       // auto octal
    add_text("+zZ", RADIX_MAX, 8'h80);      // base 36, non-ascii terminator
    add_text("", RADIX_DEC, "q");           // no digits
    add_text("-", RADIX_DEC, ".");          // sign with no digits
    add_text("1", RADIX_DEC, "2");          // still running when the next start comes
    add_text("5", RADIX_DEC, 8'h00);        // restart drops the old parse
    add_text("101", RADIX_MIN, "2");        // binary

    // random strings through the three pacing phases
    goal      = char_plan.size() + RANDOM_ITEMS;
    last_pace = PACE_RX_SLOW;
    hold_done = 1'b0;
    while (char_plan.size() < goal) begin
      k = goal - char_plan.size();
      gen_pace = (k > 2 * RANDOM_ITEMS / 3) ? PACE_RX_SLOW :
                 (k > RANDOM_ITEMS / 3)     ? PACE_TX_SLOW : PACE_FULL;
      // no random pauses at full rate, so the hold-off always backs up the input
      if (gen_pace != last_pace || (gen_pace != PACE_FULL && $urandom_range(99) < 3))
        gen_drain = 1'b1;
      last_pace = gen_pace;
      if (!hold_done && gen_pace == PACE_FULL) begin
        gen_hold  = 1'b1;
        hold_done = 1'b1;
      end

      sel = $urandom_range(99);
      if (sel < 5) begin
        // noise: random bytes, random start flags and radix
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
          opening = 1'($urandom_range(1));
          add_char(8'($urandom_range(255)), 6'($urandom_range(63)));
        end
      end else if (sel < 11) begin
        // bad radix, sometimes followed by characters that must be ignored
        rdx = $urandom_range(1) ? 6'd1 : 6'($urandom_range(63, 37));
        add_text("", rdx, 8'($urandom_range(255)));
        if ($urandom_range(1)) add_char(8'($urandom_range(255)), rdx);
      end else if (sel < 19) begin
        // around the signed range limits
        case ($urandom_range(7))
          0: add_text("9223372036854775807", RADIX_DEC, 8'h00);
          1: add_text("-9223372036854775808", RADIX_AUTO, " ");
          2: add_text("9223372036854775808", RADIX_AUTO, 8'h00);
          3: add_text("-9223372036854775809", RADIX_DEC, ",");
          4: add_text("0x7FFFFFFFFFFFFFFF", RADIX_HEX, "g");
          5: add_text("-0x8000000000000001", RADIX_AUTO, 8'h00);
          6: add_text("-1000000000000000000000000000000000000000000000000000000000000000",
                      RADIX_MIN, "2");
          default: add_text("+18446744073709551616", RADIX_DEC, 8'hFF);
        endcase
      end else begin
        // well-formed number with random content
        case ($urandom_range(9))
          0, 1:    rdx = RADIX_AUTO;
          2:       rdx = RADIX_DEC;
          3:       rdx = RADIX_HEX;
          4:       rdx = RADIX_OCT;
          5:       rdx = RADIX_MIN;
          6:       rdx = RADIX_MAX;
          default: rdx = 6'($urandom_range(36, 2));
        endcase
        base = (rdx == RADIX_AUTO) ? int'(RADIX_DEC) : int'(rdx);
        opening = 1'b1;
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          add_char($urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9)), rdx);
        end
        k = $urandom_range(2);
        if (k == 1) add_char("+", rdx);
        if (k == 2) add_char("-", rdx);
        if (rdx == RADIX_AUTO || rdx == RADIX_HEX) begin
          k = $urandom_range(5);
          if (k < 2) begin
            add_char("0", rdx);
            add_char(k != 0 ? "x" : "X", rdx);
            base = 16;
          end else if (k == 2 && rdx == RADIX_AUTO) begin
            add_char("0", rdx);
            base = 8;
          end
        end
        k = $urandom_range(99);
        n = (k < 75) ? $urandom_range(12) :
            (k < 95) ? $urandom_range(25, 13) : $urandom_range(70, 26);
        for (int i = 0; i < n; i++) add_char(digit_char($urandom_range(base - 1)), rdx);
        if ($urandom_range(1)) begin
          c = 8'h00;
        end else begin
          do c = 8'($urandom_range(255)); while (char_digit(c) < base);
        end
        // now and then no terminator, so the next start cuts this one off
        if ($urandom_range(99) >= 3) add_char(c, rdx);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (char_plan.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
